[sv/pedt_pkg.sv]
// ----------------------------------------------------------------------------
// Polled event deadline table package
// Operation and status codes, the slot entry layout and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pedt_pkg;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [2:0] ST_SPACE    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_CLEARED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  // At most this many slots fire on one tick.
  localparam int MAX_FIRE  = 16;
  localparam int FIRE_CNTW = $clog2(MAX_FIRE + 1);

  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] task_id;
    logic [31:0] task_arg;
  } slot_entry_t;

  typedef struct packed {
    logic start;   // latch the accepted transaction
    logic rd_en;   // read the slot memory at the read address
    logic ev_en;   // act on the slot that was read last
    logic finish;  // send the final result of the transaction
  } pedt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       held_valid;
    logic       out_free;
  } pedt_stat_t;

endpackage

`default_nettype wire

[sv/pedt_slot_mem.sv]
// ----------------------------------------------------------------------------
// Slot memory
// Deadline, task id and argument of every slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pedt_slot_mem #(
  parameter int SLOTS = 16,
  localparam int IDXW = $clog2(SLOTS)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [IDXW-1:0]     wr_addr,
  input  wire pedt_pkg::slot_entry_t wr_data,
  input  wire logic                rd_en,
  input  wire logic [IDXW-1:0]     rd_addr,
  output pedt_pkg::slot_entry_t    rd_data
);
  import pedt_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/pedt_ctrl.sv]
// ----------------------------------------------------------------------------
// Polled event deadline table controller
// Walks the slots one per cycle, stops the scan early where the operation
// allows and stalls while a fired result cannot leave.
// ----------------------------------------------------------------------------
`default_nettype none

module pedt_ctrl #(
  parameter int SLOTS = 16,
  localparam int IDXW = $clog2(SLOTS),
  localparam int CNTW = $clog2(SLOTS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire pedt_pkg::pedt_stat_t stat,
  output pedt_pkg::pedt_cmd_t       cmd,
  output logic [IDXW-1:0]           rd_addr,
  output logic [IDXW-1:0]           ev_idx
);
  import pedt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNTW-1:0]      rd_idx_r, rd_idx_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [IDXW-1:0]      ev_idx_r, ev_idx_nxt;
  logic [FIRE_CNTW-1:0] fire_cnt_r, fire_cnt_nxt;
  logic                 stall;
  logic                 stop;

  assign in_ready = (state_r == S_IDLE);
  assign rd_addr  = rd_idx_r[IDXW-1:0];
  assign ev_idx   = ev_idx_r;

  // A fired slot can only be taken when the held result has somewhere to go.
  assign stall = ev_valid_r && (stat.op == OP_TICK) && stat.hit &&
                 stat.held_valid && !stat.out_free;

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    ev_valid_nxt = ev_valid_r;
    ev_idx_nxt   = ev_idx_r;
    fire_cnt_nxt = fire_cnt_r;
    cmd          = '0;
    stop         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_opcode != OP_NONE) begin
            state_nxt    = S_SCAN;
            rd_idx_nxt   = '0;
            ev_valid_nxt = 1'b0;
            fire_cnt_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          cmd.ev_en = ev_valid_r;
          if (ev_valid_r) begin
            if (stat.hit && (stat.op == OP_SCHEDULE)) begin
              stop = 1'b1;
            end
            if (stat.hit && (stat.op == OP_TICK)) begin
              fire_cnt_nxt = fire_cnt_r + 1'b1;
              if (fire_cnt_r == FIRE_CNTW'(MAX_FIRE - 1)) begin
                stop = 1'b1;
              end
            end
            if (ev_idx_r == IDXW'(SLOTS - 1)) begin
              stop = 1'b1;
            end
          end
          if (stop) begin
            state_nxt    = S_FINISH;
            ev_valid_nxt = 1'b0;
          end else if (rd_idx_r < CNTW'(SLOTS)) begin
            cmd.rd_en    = 1'b1;
            ev_valid_nxt = 1'b1;
            ev_idx_nxt   = rd_idx_r[IDXW-1:0];
            rd_idx_nxt   = rd_idx_r + 1'b1;
          end else begin
            ev_valid_nxt = 1'b0;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_idx_r   <= '0;
      ev_valid_r <= 1'b0;
      ev_idx_r   <= '0;
      fire_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      ev_valid_r <= ev_valid_nxt;
      ev_idx_r   <= ev_idx_nxt;
      fire_cnt_r <= fire_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pedt_datapath.sv]
// ----------------------------------------------------------------------------
// Polled event deadline table datapath
// Tick count, pending bits, slot memory, the held result and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pedt_datapath #(
  parameter int SLOTS = 16,
  localparam int IDXW = $clog2(SLOTS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pedt_pkg::pedt_cmd_t cmd,
  input  wire logic [IDXW-1:0]     rd_addr,
  input  wire logic [IDXW-1:0]     ev_idx,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [31:0]         in_period,
  input  wire logic [15:0]         in_task_id,
  input  wire logic [31:0]         in_task_arg,
  output pedt_pkg::pedt_stat_t     stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_status,
  output logic                     out_accepted,
  output logic [3:0]               out_slot,
  output logic [15:0]              out_fired_id,
  output logic [31:0]              out_fired_arg,
  output logic                     out_last
);
  import pedt_pkg::*;

  logic [1:0]       op_r;
  logic [31:0]      period_r;
  logic [15:0]      id_r;
  logic [31:0]      arg_r;
  logic [63:0]      now_r;
  logic             found_r;
  logic [SLOTS-1:0] pending_r;

  logic             held_valid_r;
  logic [2:0]       held_status_r;
  logic             held_accepted_r;
  logic [3:0]       held_slot_r;
  logic [15:0]      held_id_r;
  logic [31:0]      held_arg_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic             out_accepted_r;
  logic [3:0]       out_slot_r;
  logic [15:0]      out_id_r;
  logic [31:0]      out_arg_r;
  logic             out_last_r;

  slot_entry_t      rd_data;
  slot_entry_t      wr_data;
  logic             we;
  logic             pend;
  logic             match;
  logic             due;
  logic             hit;
  logic             out_free;
  logic             out_load;
  logic [IDXW+3:0]  idx_ext;
  logic [3:0]       ev_slot;
  logic [2:0]       end_status;

  pedt_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .we      (we),
    .wr_addr (ev_idx),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pend     = pending_r[ev_idx];
  assign match    = (rd_data.task_id == id_r) && (rd_data.task_arg == arg_r);
  assign due      = (rd_data.deadline < now_r);
  assign out_free = !out_valid_r || out_ready;
  assign idx_ext  = {4'b0, ev_idx};
  assign ev_slot  = idx_ext[3:0];

  // The output register loads when a fired slot pushes out the one held
  // before it, or when the final result of a transaction is sent.
  assign out_load = (cmd.ev_en && hit && (op_r == OP_TICK) && held_valid_r) ||
                    cmd.finish;

  always_comb begin
    case (op_r)
      OP_SCHEDULE: hit = !pend;
      OP_CANCEL:   hit = pend && match;
      OP_TICK:     hit = pend && due;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_SCHEDULE: end_status = ST_FULL;
      OP_CANCEL:   end_status = found_r ? ST_CLEARED : ST_NOTFOUND;
      default:     end_status = ST_IDLE;
    endcase
  end

  assign we               = cmd.ev_en && (op_r == OP_SCHEDULE) && !pend;
  assign wr_data.deadline = now_r + {32'b0, period_r};
  assign wr_data.task_id  = id_r;
  assign wr_data.task_arg = arg_r;

  assign stat.op         = op_r;
  assign stat.hit        = hit;
  assign stat.held_valid = held_valid_r;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_NONE;
      now_r        <= '0;
      found_r      <= 1'b0;
      pending_r    <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.start) begin
        op_r         <= in_opcode;
        period_r     <= in_period;
        id_r         <= in_task_id;
        arg_r        <= in_task_arg;
        found_r      <= 1'b0;
        held_valid_r <= 1'b0;
        if (in_opcode == OP_TICK) begin
          now_r <= now_r + 64'd1;
        end
      end

      if (cmd.ev_en && hit) begin
        case (op_r)
          OP_SCHEDULE: begin
            pending_r[ev_idx] <= 1'b1;
            held_valid_r      <= 1'b1;
            held_status_r     <= (ev_idx == IDXW'(SLOTS - 1)) ? ST_FULL : ST_SPACE;
            held_accepted_r   <= 1'b1;
            held_slot_r       <= ev_slot;
            held_id_r         <= '0;
            held_arg_r        <= '0;
          end
          OP_CANCEL: begin
            pending_r[ev_idx] <= 1'b0;
            found_r           <= 1'b1;
          end
          OP_TICK: begin
            pending_r[ev_idx] <= 1'b0;
            // The previous fired slot is known not to be the last one now.
            if (held_valid_r) begin
              out_status_r   <= held_status_r;
              out_accepted_r <= held_accepted_r;
              out_slot_r     <= held_slot_r;
              out_id_r       <= held_id_r;
              out_arg_r      <= held_arg_r;
              out_last_r     <= 1'b0;
            end
            held_valid_r    <= 1'b1;
            held_status_r   <= ST_FIRED;
            held_accepted_r <= 1'b0;
            held_slot_r     <= ev_slot;
            held_id_r       <= rd_data.task_id;
            held_arg_r      <= rd_data.task_arg;
          end
          default: begin
          end
        endcase
      end

      if (cmd.finish) begin
        out_last_r   <= 1'b1;
        held_valid_r <= 1'b0;
        if (held_valid_r) begin
          out_status_r   <= held_status_r;
          out_accepted_r <= held_accepted_r;
          out_slot_r     <= held_slot_r;
          out_id_r       <= held_id_r;
          out_arg_r      <= held_arg_r;
        end else begin
          out_status_r   <= end_status;
          out_accepted_r <= 1'b0;
          out_slot_r     <= '0;
          out_id_r       <= '0;
          out_arg_r      <= '0;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_accepted  = out_accepted_r;
  assign out_slot      = out_slot_r;
  assign out_fired_id  = out_id_r;
  assign out_fired_arg = out_arg_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

[sv/polled_event_deadline_table.sv]
// ----------------------------------------------------------------------------
// Polled event deadline table
// A table of one-shot event slots with a 64-bit running tick count.
// ----------------------------------------------------------------------------
// Each input transaction is a schedule, a cancel or a tick, and the block
// takes one at a time: the slot memory has a single read port and is
// scanned one slot per cycle while no fired result is stalled. A
// transaction is accepted, then reads the slots in order through the
// registered read port, then sends the final result. A schedule stops at
// the lowest empty slot and so finishes sooner when there is room near the
// bottom; a tick that fires stops after its sixteenth fired slot, and
// stalls whenever a fired result waits on a full output register. Results
// leave through an output register, so the next transaction can be
// accepted while the final result of the previous one still waits to be
// taken. Every transaction except the unused opcode produces at least one
// result, and the final result carries out_last. The pending bits are
// flip-flops cleared by reset, so the block is ready right after reset
// with no clearing pass over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module polled_event_deadline_table #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_period,
  input  wire logic [15:0] in_task_id,
  input  wire logic [31:0] in_task_arg,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_accepted,
  output logic [3:0]       out_slot,
  output logic [15:0]      out_fired_id,
  output logic [31:0]      out_fired_arg,
  output logic             out_last
);
  import pedt_pkg::*;

  localparam int IDXW = $clog2(SLOTS);

  pedt_cmd_t       cmd;
  pedt_stat_t      stat;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] ev_idx;

  // The controller owns the scan position and the sequencing of results.
  pedt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .ev_idx    (ev_idx)
  );

  // The datapath holds the slots, the tick count and the result registers.
  pedt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .ev_idx        (ev_idx),
    .in_opcode     (in_opcode),
    .in_period     (in_period),
    .in_task_id    (in_task_id),
    .in_task_arg   (in_task_arg),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_accepted  (out_accepted),
    .out_slot      (out_slot),
    .out_fired_id  (out_fired_id),
    .out_fired_arg (out_fired_arg),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
